[hw/rtl/jump_chain_exit_counter_top_macros.svh]
// Assertion macros for the jump chain exit counter checker.
// Needs clk and rst_n in the scope of each use.
`ifndef JUMP_CHAIN_EXIT_COUNTER_TOP_MACROS_SVH
`define JUMP_CHAIN_EXIT_COUNTER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define JCEC_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a beat condition is followed by a condition in the next cycle.
`define JCEC_CHECK_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error(msg);

`endif

[hw/rtl/jcec_pkg.sv]
// Shared constants and types for the jump chain exit counter.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package jcec_pkg;

  localparam int unsigned MAX_POSITIONS = 1024;
  localparam int unsigned BLOCK_SIZE    = 32;

  localparam int unsigned POS_W   = 10;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned STR_W   = 11;
  localparam int unsigned EXIT_W  = 11;
  localparam int unsigned TOTAL_W = 11;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 11'd2047;

  localparam int unsigned DIV_SHIFT = 18;

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic             str_we;
    logic [POS_W-1:0] str_addr;
    logic             exit_we;
    logic [POS_W-1:0] exit_waddr;
    logic [POS_W-1:0] exit_raddr;
  } tbl_req_t;

endpackage

`default_nettype wire

[hw/rtl/jump_chain_exit_counter_top.sv]
// Top level of the jump chain exit counter.
// Depends on jcec_pkg, jcec_seq and jcec_tables.
//
//   channel  ports                                       handshake
//   in       in_command in_position in_strength          start & !busy
//   out      out_jump_total                              out_valid strobe
//   cfg      cfg_wdata                                   cfg_we
//
// A write walks the states S_DIV, S_BASE, S_LAST and S_RSTR, then an S_TGT and S_WB pair per
// entry of its block (at most BLOCK_SIZE entries), one strength read and exit read/write each.
// A write at or beyond position_count is dropped in idle and leaves the tables alone.
// A query alternates S_QRD and S_QEV, one exit memory read per block walked.
// Reset is synchronous and clears the sequencer and position_count (1024);
// the memories hold garbage until written. No stall on the result side.
`default_nettype none

module jump_chain_exit_counter_top #(
  parameter int unsigned BLOCK_SIZE = jcec_pkg::BLOCK_SIZE
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_command,
  input  wire logic [jcec_pkg::POS_W-1:0]    in_position,
  input  wire logic [jcec_pkg::STR_W-1:0]    in_strength,
  output logic                               out_valid,
  output logic      [jcec_pkg::TOTAL_W-1:0]  out_jump_total,
  input  wire logic                          cfg_we,
  input  wire logic [jcec_pkg::CNT_W-1:0]    cfg_wdata
);

  localparam int unsigned STEP_W = $clog2(BLOCK_SIZE + 1);

  jcec_pkg::tbl_req_t            tbl_req;
  logic [jcec_pkg::STR_W-1:0]    str_wdata, str_rdata;
  logic [jcec_pkg::EXIT_W-1:0]   exit_wdata, exit_rdata;
  logic [STEP_W-1:0]             step_wdata, step_rdata;

  jcec_seq #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_position    (in_position),
    .in_strength    (in_strength),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_jump_total (out_jump_total),
    .tbl_req        (tbl_req),
    .str_wdata      (str_wdata),
    .exit_wdata     (exit_wdata),
    .step_wdata     (step_wdata),
    .str_rdata      (str_rdata),
    .exit_rdata     (exit_rdata),
    .step_rdata     (step_rdata)
  );

  jcec_tables #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_tables (
    .clk        (clk),
    .tbl_req    (tbl_req),
    .str_wdata  (str_wdata),
    .exit_wdata (exit_wdata),
    .step_wdata (step_wdata),
    .str_rdata  (str_rdata),
    .exit_rdata (exit_rdata),
    .step_rdata (step_rdata)
  );

endmodule

`default_nettype wire

[hw/rtl/jcec_alu.sv]
// Shared add and compare unit of the jump chain exit counter.
// Depends on jcec_pkg.
`default_nettype none

module jcec_alu (
  input  wire logic [jcec_pkg::CNT_W-1:0] a,
  input  wire logic [jcec_pkg::CNT_W-1:0] b,
  input  wire logic [jcec_pkg::CNT_W-1:0] limit,
  output logic      [jcec_pkg::CNT_W:0]   sum,
  output logic                            over
);

  assign sum  = {1'b0, a} + {1'b0, b};
  assign over = sum > {1'b0, limit};

endmodule

`default_nettype wire

[hw/rtl/jcec_tables.sv]
// Strength, exit and step memories of the jump chain exit counter.
// Depends on jcec_pkg; registered reads, one write port per memory.
`default_nettype none

module jcec_tables #(
  parameter int unsigned BLOCK_SIZE = jcec_pkg::BLOCK_SIZE
) (
  input  wire logic                                 clk,
  input  wire jcec_pkg::tbl_req_t                   tbl_req,
  input  wire logic [jcec_pkg::STR_W-1:0]           str_wdata,
  input  wire logic [jcec_pkg::EXIT_W-1:0]          exit_wdata,
  input  wire logic [$clog2(BLOCK_SIZE+1)-1:0]      step_wdata,
  output logic      [jcec_pkg::STR_W-1:0]           str_rdata,
  output logic      [jcec_pkg::EXIT_W-1:0]          exit_rdata,
  output logic      [$clog2(BLOCK_SIZE+1)-1:0]      step_rdata
);

  localparam int unsigned STEP_W = $clog2(BLOCK_SIZE + 1);

  logic [jcec_pkg::STR_W-1:0]  str_mem  [jcec_pkg::MAX_POSITIONS];
  logic [jcec_pkg::EXIT_W-1:0] exit_mem [jcec_pkg::MAX_POSITIONS];
  logic [STEP_W-1:0]           step_mem [jcec_pkg::MAX_POSITIONS];

  always_ff @(posedge clk) begin
    if (tbl_req.str_we) begin
      str_mem[tbl_req.str_addr] <= str_wdata;
    end
    str_rdata <= str_mem[tbl_req.str_addr];
  end

  always_ff @(posedge clk) begin
    if (tbl_req.exit_we) begin
      exit_mem[tbl_req.exit_waddr] <= exit_wdata;
      step_mem[tbl_req.exit_waddr] <= step_wdata;
    end
    exit_rdata <= exit_mem[tbl_req.exit_raddr];
    step_rdata <= step_mem[tbl_req.exit_raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/jcec_seq.sv]
// Sequencer of the jump chain exit counter: block rebuild and block walk.
// Depends on jcec_pkg and jcec_alu; drives the jcec_tables ports.
`default_nettype none

module jcec_seq #(
  parameter int unsigned BLOCK_SIZE = jcec_pkg::BLOCK_SIZE
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_command,
  input  wire logic [jcec_pkg::POS_W-1:0]         in_position,
  input  wire logic [jcec_pkg::STR_W-1:0]         in_strength,
  input  wire logic                               cfg_we,
  input  wire logic [jcec_pkg::CNT_W-1:0]         cfg_wdata,
  output logic                                    out_valid,
  output logic      [jcec_pkg::TOTAL_W-1:0]       out_jump_total,
  output jcec_pkg::tbl_req_t                      tbl_req,
  output logic      [jcec_pkg::STR_W-1:0]         str_wdata,
  output logic      [jcec_pkg::EXIT_W-1:0]        exit_wdata,
  output logic      [$clog2(BLOCK_SIZE+1)-1:0]    step_wdata,
  input  wire logic [jcec_pkg::STR_W-1:0]         str_rdata,
  input  wire logic [jcec_pkg::EXIT_W-1:0]        exit_rdata,
  input  wire logic [$clog2(BLOCK_SIZE+1)-1:0]    step_rdata
);

  localparam int unsigned POS_W   = jcec_pkg::POS_W;
  localparam int unsigned CNT_W   = jcec_pkg::CNT_W;
  localparam int unsigned STEP_W  = $clog2(BLOCK_SIZE + 1);
  localparam int unsigned RECIP_W = jcec_pkg::DIV_SHIFT + 1;
  localparam int unsigned RECIP   =
    ((1 << jcec_pkg::DIV_SHIFT) + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(jcec_pkg::MAX_POSITIONS);
  localparam logic [CNT_W-1:0] BLK_M1  = CNT_W'(BLOCK_SIZE - 1);
  localparam int unsigned STR_W_LOCAL = jcec_pkg::STR_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_BASE = 4'd2;
  localparam logic [3:0] S_LAST = 4'd3;
  localparam logic [3:0] S_RSTR = 4'd4;
  localparam logic [3:0] S_TGT  = 4'd5;
  localparam logic [3:0] S_WB   = 4'd6;
  localparam logic [3:0] S_QRD  = 4'd7;
  localparam logic [3:0] S_QEV  = 4'd8;

  logic [3:0]                    state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [POS_W-1:0]              pos_r, pos_nxt;
  logic [POS_W-1:0]              q_r, q_nxt;
  logic [POS_W-1:0]              first_r, first_nxt;
  logic [POS_W-1:0]              last_r, last_nxt;
  logic [POS_W-1:0]              i_r, i_nxt;
  logic [jcec_pkg::EXIT_W-1:0]   t_r, t_nxt;
  logic                          far_r, far_nxt;
  logic [CNT_W-1:0]              x_r, x_nxt;
  logic [jcec_pkg::TOTAL_W-1:0]  total_r, total_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [jcec_pkg::TOTAL_W-1:0]  out_total_r, out_total_nxt;

  logic [POS_W+RECIP_W-1:0]      div_prod;
  logic [POS_W+STEP_W-1:0]       base_prod;
  logic [CNT_W-1:0]              blk_end;
  logic [CNT_W-1:0]              cnt_m1;
  logic [CNT_W-1:0]              alu_a, alu_b, alu_lim;
  logic [CNT_W:0]                alu_sum;
  logic                          alu_over;
  logic [STR_W_LOCAL-1:0]        str_sat;

  jcec_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .limit (alu_lim),
    .sum   (alu_sum),
    .over  (alu_over)
  );

  assign div_prod  = {{RECIP_W{1'b0}}, pos_r} * (POS_W+RECIP_W)'(RECIP);
  assign base_prod = {{STEP_W{1'b0}}, q_r} * (POS_W+STEP_W)'(BLOCK_SIZE);
  assign blk_end   = {1'b0, first_r} + BLK_M1;
  assign cnt_m1    = count_r - CNT_W'(1);

  assign str_sat = (in_strength > CNT_MAX) ? CNT_MAX :
                   (in_strength == '0)     ? STR_W_LOCAL'(1) : in_strength;

  assign str_wdata  = str_sat;
  assign exit_wdata = far_r ? t_r : exit_rdata;
  assign step_wdata = far_r ? STEP_W'(1) : step_rdata + STEP_W'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    q_nxt         = q_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    i_nxt         = i_r;
    t_nxt         = t_r;
    far_nxt       = far_r;
    x_nxt         = x_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    out_total_nxt = out_total_r;

    tbl_req            = '0;
    tbl_req.str_addr   = i_r;
    tbl_req.exit_waddr = i_r;
    tbl_req.exit_raddr = x_r[POS_W-1:0];

    alu_a   = {1'b0, i_r};
    alu_b   = str_rdata;
    alu_lim = {1'b0, last_r};

    if (cfg_we) begin
      count_nxt = (cfg_wdata > CNT_MAX) ? CNT_MAX : cfg_wdata;
    end

    unique case (state_r)
      S_IDLE: begin
        tbl_req.str_addr = in_position;
        if (start) begin
          pos_nxt = in_position;
          if (in_command == jcec_pkg::CMD_WRITE) begin
            if ({1'b0, in_position} < count_r) begin
              tbl_req.str_we = 1'b1;
              state_nxt      = S_DIV;
            end
          end else begin
            x_nxt     = {1'b0, in_position};
            total_nxt = '0;
            state_nxt = S_QRD;
          end
        end
      end
      S_DIV: begin
        q_nxt     = div_prod[jcec_pkg::DIV_SHIFT +: POS_W];
        state_nxt = S_BASE;
      end
      S_BASE: begin
        first_nxt = base_prod[POS_W-1:0];
        state_nxt = S_LAST;
      end
      S_LAST: begin
        last_nxt  = (blk_end < cnt_m1) ? blk_end[POS_W-1:0] : cnt_m1[POS_W-1:0];
        i_nxt     = last_nxt;
        state_nxt = S_RSTR;
      end
      S_RSTR: begin
        state_nxt = S_TGT;
      end
      S_TGT: begin
        tbl_req.exit_raddr = alu_sum[POS_W-1:0];
        t_nxt              = alu_sum[jcec_pkg::EXIT_W-1:0];
        far_nxt            = alu_over;
        state_nxt          = S_WB;
      end
      S_WB: begin
        tbl_req.exit_we  = 1'b1;
        tbl_req.str_addr = i_r - POS_W'(1);
        if (i_r == first_r) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r - POS_W'(1);
          state_nxt = S_TGT;
        end
      end
      S_QRD: begin
        if (x_r < count_r) begin
          state_nxt = S_QEV;
        end else begin
          out_valid_nxt = 1'b1;
          out_total_nxt = total_r;
          state_nxt     = S_IDLE;
        end
      end
      S_QEV: begin
        alu_a   = total_r;
        alu_b   = {{(CNT_W-STEP_W){1'b0}}, step_rdata};
        alu_lim = jcec_pkg::TOTAL_MAX;
        if (exit_rdata <= x_r) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = total_r;
          state_nxt     = S_IDLE;
        end else begin
          total_nxt = alu_over ? jcec_pkg::TOTAL_MAX : alu_sum[jcec_pkg::TOTAL_W-1:0];
          x_nxt     = exit_rdata;
          state_nxt = S_QRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_MAX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    q_r         <= q_nxt;
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    i_r         <= i_nxt;
    t_r         <= t_nxt;
    far_r       <= far_nxt;
    x_r         <= x_nxt;
    total_r     <= total_nxt;
    out_total_r <= out_total_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_jump_total = out_total_r;

endmodule

`default_nettype wire

[hw/rtl/jcec_checker.sv]
// Port-level checker for the jump chain exit counter, bound to the top level.
// Depends on jcec_pkg and jump_chain_exit_counter_top_macros.svh.
`default_nettype none

`include "jump_chain_exit_counter_top_macros.svh"

module jcec_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_command,
  input wire logic out_valid
);

  logic query_beat;
  logic write_beat;

  assign query_beat = start && !busy && (in_command == jcec_pkg::CMD_QUERY);
  assign write_beat = start && !busy && (in_command == jcec_pkg::CMD_WRITE);

  `JCEC_CHECK_NEXT(a_query_goes_busy, query_beat, busy, "query beat did not start a walk")
  `JCEC_CHECK_NEXT(a_write_no_result, write_beat, !out_valid, "write beat gave a result")
  `JCEC_CHECK_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe held two cycles")
  `JCEC_CHECK(a_result_when_idle, out_valid |-> (!busy && $past(busy)), "result outside a walk end")

endmodule

bind jump_chain_exit_counter_top jcec_checker u_jcec_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_command (in_command),
  .out_valid  (out_valid)
);

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for jump_chain_exit_counter_top: jump strength writes and
// jump-count queries against an in-bench predictor of the block tables.
// Depends on jcec_pkg and the top level only.
module testbench;
  import jcec_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_command = CMD_QUERY;
  logic [POS_W-1:0]     in_position = '0;
  logic [STR_W-1:0]     in_strength = '0;
  logic                 out_valid;
  logic [TOTAL_W-1:0]   out_jump_total;
  logic                 cfg_we = 1'b0;
  logic [CNT_W-1:0]     cfg_wdata = '0;

  logic [STR_W-1:0]     strength_mem [MAX_POSITIONS];
  logic [11:0]          exit_mem [MAX_POSITIONS];
  logic [5:0]           step_mem [MAX_POSITIONS];
  int unsigned          active_count = MAX_POSITIONS;
  logic [TOTAL_W-1:0]   jump_totals_due [$];
  int unsigned          mismatch_count = 0;
  bit                   idling_on = 1'b1;

  jump_chain_exit_counter_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_position    (in_position),
    .in_strength    (in_strength),
    .out_valid      (out_valid),
    .out_jump_total (out_jump_total),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void rebuild_exit_block(input int unsigned pos);
    int unsigned lo;
    int unsigned hi;
    int unsigned hop;
    lo = (pos / BLOCK_SIZE) * BLOCK_SIZE;
    hi = lo + BLOCK_SIZE - 1;
    if (hi > active_count - 1) begin
      hi = active_count - 1;
    end
    for (int i = int'(hi); i >= int'(lo); i--) begin
      hop = i + strength_mem[i];
      if (hop > hi) begin
        exit_mem[i] = hop[11:0];
        step_mem[i] = 6'd1;
      end else begin
        exit_mem[i] = exit_mem[hop];
        step_mem[i] = step_mem[hop] + 6'd1;
      end
    end
  endfunction

  function automatic void store_strength(input int unsigned pos, input int unsigned strength);
    int unsigned eff;
    if (pos < active_count) begin
      eff = (strength > MAX_POSITIONS) ? MAX_POSITIONS : strength;
      if (eff == 0) begin
        eff = 1;
      end
      strength_mem[pos] = eff[STR_W-1:0];
      rebuild_exit_block(pos);
    end
  endfunction

  function automatic logic [TOTAL_W-1:0] count_jumps(input int unsigned pos);
    int unsigned x;
    int unsigned nx;
    int unsigned total;
    x = pos;
    total = 0;
    while (x < active_count) begin
      nx = exit_mem[x];
      if (nx <= x) break;
      total += step_mem[x];
      if (total > TOTAL_MAX) begin
        total = TOTAL_MAX;
      end
      x = nx;
    end
    return total[TOTAL_W-1:0];
  endfunction

  function automatic logic [STR_W-1:0] rand_strength();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 70) return STR_W'($urandom_range(1, 4));
    if (r < 85) return STR_W'($urandom_range(5, 64));
    return STR_W'($urandom_range(65, 2047));
  endfunction

  function automatic logic [POS_W-1:0] rand_position();
    if (active_count == 0 || $urandom_range(0, 99) < 15) begin
      return POS_W'($urandom_range(0, MAX_POSITIONS - 1));
    end
    return POS_W'($urandom_range(0, active_count - 1));
  endfunction

  // hold start through the gap decision; drop it only for a real gap
  task automatic idle_gap();
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(0, 99);
    gap = 0;
    if (idling_on) begin
      if (r >= 60 && r < 90) gap = $urandom_range(1, 3);
      else if (r >= 90) gap = $urandom_range(4, 100);
    end
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_command(input logic cmd, input logic [POS_W-1:0] pos,
                              input logic [STR_W-1:0] strength);
    start = 1'b1;
    in_command = cmd;
    in_position = pos;
    in_strength = strength;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (cmd == CMD_WRITE) begin
      store_strength(pos, strength);
    end else begin
      jump_totals_due.push_back(count_jumps(pos));
    end
    @(negedge clk);
    idle_gap();
  endtask

  task automatic settle();
    start = 1'b0;
    while (jump_totals_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_position_count(input logic [CNT_W-1:0] value);
    settle();
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    active_count = (value > MAX_POSITIONS) ? MAX_POSITIONS : value;
  endtask

  task automatic run_mixed(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 1) == 1) begin
        send_command(CMD_WRITE, rand_position(), rand_strength());
      end else begin
        send_command(CMD_QUERY, rand_position(), STR_W'($urandom));
      end
    end
  endtask

  task automatic test_full_load();
    for (int p = 0; p < MAX_POSITIONS; p++) begin
      send_command(CMD_WRITE, POS_W'(p), rand_strength());
    end
    run_mixed(100);
  endtask

  task automatic test_corner_values();
    send_command(CMD_WRITE, 10'd0, 11'd0);
    send_command(CMD_WRITE, 10'd1023, 11'd2047);
    send_command(CMD_WRITE, 10'd1, 11'd1024);
    send_command(CMD_WRITE, 10'd2, 11'd2);
    send_command(CMD_QUERY, 10'd0, 11'd2047);
    send_command(CMD_QUERY, 10'd1023, 11'd0);
    send_command(CMD_QUERY, 10'd1, 11'd0);
    send_command(CMD_QUERY, 10'd2, 11'd0);
    send_command(CMD_WRITE, 10'd1022, 11'd1);
    send_command(CMD_QUERY, 10'd1022, 11'd0);
    set_position_count(11'd0);
    send_command(CMD_QUERY, 10'd0, 11'd0);
    send_command(CMD_WRITE, 10'd5, 11'd7);
    send_command(CMD_QUERY, 10'd1023, 11'd0);
    set_position_count(11'd1);
    send_command(CMD_WRITE, 10'd0, 11'd3);
    send_command(CMD_QUERY, 10'd0, 11'd0);
    send_command(CMD_QUERY, 10'd1, 11'd0);
    send_command(CMD_WRITE, 10'd512, 11'd9);
    set_position_count(11'd2047);
    send_command(CMD_QUERY, 10'd0, 11'd0);
    send_command(CMD_QUERY, 10'd512, 11'd0);
    send_command(CMD_QUERY, 10'd31, 11'd0);
    send_command(CMD_WRITE, 10'd31, 11'd1);
    send_command(CMD_QUERY, 10'd0, 11'd0);
    set_position_count(11'd33);
    send_command(CMD_WRITE, 10'd32, 11'd1);
    send_command(CMD_QUERY, 10'd32, 11'd0);
    send_command(CMD_QUERY, 10'd0, 11'd0);
  endtask

  task automatic test_count_sweep();
    logic [CNT_W-1:0] counts [12];
    counts = '{11'd1, 11'd2, 11'd31, 11'd32, 11'd33, 11'd500, 11'd1023, 11'd1024,
               11'd2047, 11'd0, 11'd0, 11'd0};
    counts[10] = CNT_W'($urandom_range(1, MAX_POSITIONS));
    counts[11] = CNT_W'($urandom_range(1, MAX_POSITIONS));
    foreach (counts[k]) begin
      set_position_count(counts[k]);
      idling_on = ($urandom_range(0, 3) != 0);
      run_mixed(67);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (jump_totals_due.size() == 0) begin
        $error("jump_total beat with no query pending: actual %0d", out_jump_total);
        mismatch_count++;
      end else if (out_jump_total !== jump_totals_due[0]) begin
        $error("jump_total mismatch: expected %0d, actual %0d",
               jump_totals_due[0], out_jump_total);
        mismatch_count++;
        void'(jump_totals_due.pop_front());
      end else begin
        void'(jump_totals_due.pop_front());
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_full_load();
    settle();
    test_corner_values();
    settle();
    test_count_sweep();
    settle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
